>>> hdl/psd_pkg.sv
`default_nettype none

package psd_pkg;

	// Default coordinate width in bits (Q15.8 with the default fraction).
	localparam int COORD_WIDTH = 24;

	// Where the projection of the point falls relative to the segment.
	typedef enum logic [1:0] {
		REG_BEFORE = 2'd0,
		REG_BEYOND = 2'd1,
		REG_WITHIN = 2'd2
	} region_t;

endpackage

`default_nettype wire

>>> hdl/point_segment_distance.sv
`default_nettype none

// Distance from a 3D point to a segment, in signed fixed point with any fraction
// width (the fraction passes through unchanged). One item enters every cycle while no
// result is held at the output. Most of the pipeline is the two bit-per-stage units:
// COORD_WIDTH stages of long division for the projection and COORD_WIDTH+1 stages
// of square root for the length. The whole pipeline advances together, so it holds
// when a result waits at the output. The closest point is rounded toward negative
// infinity. Inside the segment the distance is the floor of the length. Before the
// start or past the end the distance is negated and rounded down, and region tells
// the three cases apart.
module point_segment_distance #(
	parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	input  wire logic signed [COORD_WIDTH-1:0] point_z,
	input  wire logic signed [COORD_WIDTH-1:0] start_x,
	input  wire logic signed [COORD_WIDTH-1:0] start_y,
	input  wire logic signed [COORD_WIDTH-1:0] start_z,
	input  wire logic signed [COORD_WIDTH-1:0] end_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_y,
	input  wire logic signed [COORD_WIDTH-1:0] end_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH+1:0]      signed_distance,
	output logic signed [COORD_WIDTH-1:0]      closest_x,
	output logic signed [COORD_WIDTH-1:0]      closest_y,
	output logic signed [COORD_WIDTH-1:0]      closest_z,
	output psd_pkg::region_t                   region
);
	import psd_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int LW = 2 * W + 2;
	localparam int SW = 2 * W + 3;
	localparam int RW = LW + 2;

	typedef logic [2:0][W-1:0]  crd3_t;
	typedef logic [2:0][DW-1:0] dif3_t;
	typedef logic [2:0][PW-1:0] prd3_t;

	// Context that rides through the division stages.
	typedef struct packed {
		region_t            region;
		logic               zero_len;
		logic [2:0]         neg;
		crd3_t              p;
		crd3_t              s;
		crd3_t              e;
		logic [LW-1:0]      dotu;
		logic [LW-1:0]      len2;
		logic [2:0][W-1:0]  mag;
		logic [2:0][LW-1:0] rem;
		logic [2:0][W-1:0]  quo;
	} div_t;

	// Context that rides through the square root stages.
	typedef struct packed {
		region_t       region;
		crd3_t         cl;
		logic [LW-1:0] rad;
		logic [W:0]    root;
	} sqr_t;

	logic en;

	logic  v_s1, v_s2, v_s3, v_s5, v_s6, v_s7;
	crd3_t p_s1, s_s1, e_s1, p_s2, s_s2, e_s2, p_s3, s_s3, e_s3;
	dif3_t to_s1, dir_s1, dir_s2, dir_s3;
	prd3_t dt_s2, dd_s2;
	logic signed [SW-1:0] dot_s3;
	logic [LW-1:0] len2_s3;

	div_t dv [0:W];
	logic dv_v [0:W];
	sqr_t sq [0:W+1];
	logic sq_v [0:W+1];

	region_t reg_s5, reg_s6, reg_s7;
	crd3_t cl_s5, p_s5, cl_s6, cl_s7;
	dif3_t diff_s6;
	logic [2:0][2*W:0] sqr_s7;

	logic out_valid_q;

	// The whole pipeline advances unless a finished result is held at the output.
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			dv_v[0] <= 1'b0;
			sq_v[0] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			dv_v[0] <= v_s3;
			v_s5 <= dv_v[W];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			sq_v[0] <= v_s7;
			out_valid_q <= sq_v[W+1];
		end
	end

	// Stage 1: offsets of the point and the end from the start.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= {point_z, point_y, point_x};
			s_s1 <= {start_z, start_y, start_x};
			e_s1 <= {end_z, end_y, end_x};
			to_s1 <= {DW'(point_z) - DW'(start_z), DW'(point_y) - DW'(start_y),
				DW'(point_x) - DW'(start_x)};
			dir_s1 <= {DW'(end_z) - DW'(start_z), DW'(end_y) - DW'(start_y),
				DW'(end_x) - DW'(start_x)};
		end
	end

	// Stage 2: the six products for the dot product and the squared length.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dt_s2[i] <= $signed(dir_s1[i]) * $signed(to_s1[i]);
				dd_s2[i] <= $signed(dir_s1[i]) * $signed(dir_s1[i]);
			end
			dir_s2 <= dir_s1;
			p_s2 <= p_s1;
			s_s2 <= s_s1;
			e_s2 <= e_s1;
		end
	end

	// Stage 3: sums.
	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3 <= SW'($signed(dt_s2[0])) + SW'($signed(dt_s2[1])) + SW'($signed(dt_s2[2]));
			len2_s3 <= LW'(dd_s2[0]) + LW'(dd_s2[1]) + LW'(dd_s2[2]);
			dir_s3 <= dir_s2;
			p_s3 <= p_s2;
			s_s3 <= s_s2;
			e_s3 <= e_s2;
		end
	end

	// Stage 4: classify the projection and set up the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			if (dot_s3[SW-1]) begin
				dv[0].region <= REG_BEFORE;
			end else if ((SW)'(len2_s3) < dot_s3) begin
				dv[0].region <= REG_BEYOND;
			end else begin
				dv[0].region <= REG_WITHIN;
			end
			dv[0].dotu <= (!dot_s3[SW-1] && (SW)'(len2_s3) >= dot_s3) ?
				dot_s3[LW-1:0] : '0;
			dv[0].len2 <= len2_s3;
			dv[0].zero_len <= (len2_s3 == '0);
			for (int i = 0; i < 3; i++) begin
				dv[0].neg[i] <= dir_s3[i][DW-1];
				dv[0].mag[i] <= dir_s3[i][DW-1] ? W'(-dir_s3[i]) : dir_s3[i][W-1:0];
			end
			dv[0].p <= p_s3;
			dv[0].s <= s_s3;
			dv[0].e <= e_s3;
			dv[0].rem <= '0;
			dv[0].quo <= '0;
		end
	end

	// Division stages: each takes one bit of |dir| and yields a quotient digit 0..2
	// of dot*|dir|/len2, since the partial remainder stays below len2 and dot <= len2.
	for (genvar k = 0; k < W; k++) begin : g_div
		div_t nxt;
		always_comb begin
			logic [RW-1:0] t;
			nxt = dv[k];
			for (int i = 0; i < 3; i++) begin
				t = RW'({dv[k].rem[i], 1'b0}) +
					(dv[k].mag[i][W-1-k] ? RW'(dv[k].dotu) : RW'(0));
				if (t >= RW'({dv[k].len2, 1'b0})) begin
					t = t - RW'({dv[k].len2, 1'b0});
					nxt.quo[i] = {dv[k].quo[i][W-2:0], 1'b0} + W'(2);
				end else if (t >= RW'(dv[k].len2)) begin
					t = t - RW'(dv[k].len2);
					nxt.quo[i] = {dv[k].quo[i][W-2:0], 1'b0} + W'(1);
				end else begin
					nxt.quo[i] = {dv[k].quo[i][W-2:0], 1'b0};
				end
				nxt.rem[i] = t[LW-1:0];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (en) begin
				dv_v[k+1] <= dv_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv[k+1] <= nxt;
			end
		end
	end

	// Stage 5: closest point, with the offset floored when the direction is negative.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [DW-1:0] off;
				off = $signed(DW'(dv[W].quo[i]));
				if (dv[W].neg[i]) begin
					off = -off - $signed(DW'(dv[W].rem[i] != '0));
				end
				if (dv[W].zero_len) begin
					off = '0;
				end
				unique case (dv[W].region)
					REG_BEFORE: cl_s5[i] <= dv[W].s[i];
					REG_BEYOND: cl_s5[i] <= dv[W].e[i];
					default:    cl_s5[i] <= W'(DW'($signed(dv[W].s[i])) + off);
				endcase
			end
			p_s5 <= dv[W].p;
			reg_s5 <= dv[W].region;
		end
	end

	// Stage 6: vector from the closest point to the query point.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				diff_s6[i] <= DW'($signed(p_s5[i])) - DW'($signed(cl_s5[i]));
			end
			cl_s6 <= cl_s5;
			reg_s6 <= reg_s5;
		end
	end

	// Stage 7: squares.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [PW-1:0] pr;
				pr = $signed(diff_s6[i]) * $signed(diff_s6[i]);
				sqr_s7[i] <= pr[2*W:0];
			end
			cl_s7 <= cl_s6;
			reg_s7 <= reg_s6;
		end
	end

	// Stage 8: squared length, entering the square root.
	always_ff @(posedge clk) begin
		if (en) begin
			sq[0].rad <= LW'(sqr_s7[0]) + LW'(sqr_s7[1]) + LW'(sqr_s7[2]);
			sq[0].root <= '0;
			sq[0].cl <= cl_s7;
			sq[0].region <= reg_s7;
		end
	end

	// Square root stages: one root bit each, from the top; rad keeps value - root^2.
	for (genvar j = 0; j <= W; j++) begin : g_sqrt
		localparam int B = W - j;
		sqr_t nxt;
		always_comb begin
			logic [RW-1:0] trial;
			nxt = sq[j];
			trial = (RW'(sq[j].root) << (B + 1)) + (RW'(1) << (2 * B));
			if (RW'(sq[j].rad) >= trial) begin
				nxt.rad = sq[j].rad - trial[LW-1:0];
				nxt.root = sq[j].root | ((W+1)'(1) << B);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j+1] <= 1'b0;
			end else if (en) begin
				sq_v[j+1] <= sq_v[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq[j+1] <= nxt;
			end
		end
	end

	// Output register: outside the segment the length is rounded up, then negated.
	always_ff @(posedge clk) begin
		if (en) begin
			if (sq[W+1].region == REG_WITHIN) begin
				signed_distance <= $signed((W+2)'(sq[W+1].root));
			end else begin
				signed_distance <= -$signed((W+2)'(sq[W+1].root) +
					(W+2)'(sq[W+1].rad != '0));
			end
			closest_x <= sq[W+1].cl[0];
			closest_y <= sq[W+1].cl[1];
			closest_z <= sq[W+1].cl[2];
			region <= sq[W+1].region;
		end
	end

	assign out_valid = out_valid_q;

	// A distance inside the segment is never negative.
	a_within_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region == REG_WITHIN |-> !signed_distance[W+1])
		else $error("negative distance inside the segment");

	// A distance outside the segment is never positive.
	a_outside_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region != REG_WITHIN |-> signed_distance[W+1] || signed_distance == '0)
		else $error("positive distance outside the segment");

	// A held result does not let a new item in.
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while the pipeline is held");

endmodule

`default_nettype wire

>>> sim/tb_point_segment_distance.sv
`default_nettype none

module tb_point_segment_distance;
	import psd_pkg::*;

	localparam int CW = psd_pkg::COORD_WIDTH;
	localparam int DW = CW + 2;
	localparam int LATENCY = 2 * CW + 10;
	localparam int N_RANDOM = 1450;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		logic signed [DW-1:0] sdist;
		coord_t cx;
		coord_t cy;
		coord_t cz;
		region_t reg_code;
	} distance_result_t;

	// Predicts the closest point and signed distance for each accepted item
	// and checks the block's results in order.
	class distance_scoreboard;
		distance_result_t pending[$];
		int errors;
		int n_checked;
		int n_region[3];

		function new();
			errors = 0;
			n_checked = 0;
			n_region = '{0, 0, 0};
		endfunction

		// Floor square root of a nonnegative value.
		function automatic logic [63:0] isqrt(logic [127:0] s);
			logic [63:0] r;
			logic [63:0] c;
			r = 0;
			for (int b = 63; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if ({64'd0, c} * {64'd0, c} <= s)
					r = c;
			end
			return r;
		endfunction

		function automatic distance_result_t predict(coord_t p[3], coord_t s[3],
				coord_t e[3]);
			distance_result_t res;
			logic signed [127:0] to_v[3];
			logic signed [127:0] dir[3];
			logic signed [127:0] cl[3];
			logic signed [127:0] dot;
			logic signed [127:0] len2;
			logic signed [127:0] num;
			logic signed [127:0] q;
			logic signed [127:0] dv;
			logic [127:0] sq;
			logic [63:0] root;
			dot = 0;
			len2 = 0;
			for (int i = 0; i < 3; i++) begin
				to_v[i] = 128'(p[i]) - 128'(s[i]);
				dir[i] = 128'(e[i]) - 128'(s[i]);
				dot += dir[i] * to_v[i];
				len2 += dir[i] * dir[i];
			end
			if (dot < 0) begin
				res.reg_code = REG_BEFORE;
				for (int i = 0; i < 3; i++) cl[i] = s[i];
			end else if (dot > len2) begin
				res.reg_code = REG_BEYOND;
				for (int i = 0; i < 3; i++) cl[i] = e[i];
			end else begin
				res.reg_code = REG_WITHIN;
				for (int i = 0; i < 3; i++) begin
					q = 0;
					if (len2 != 0) begin
						// Floor division of dir*dot by a positive length.
						num = dir[i] * dot;
						q = num / len2;
						if (num < 0 && q * len2 != num)
							q = q - 1;
					end
					cl[i] = 128'(s[i]) + q;
				end
			end
			sq = 0;
			for (int i = 0; i < 3; i++) begin
				dv = 128'(p[i]) - cl[i];
				sq += dv * dv;
			end
			root = isqrt(sq);
			if (res.reg_code == REG_WITHIN) begin
				res.sdist = DW'(root);
			end else begin
				// Outside the segment the length is rounded up, then negated.
				if ({64'd0, root} * {64'd0, root} != sq)
					root = root + 1;
				res.sdist = DW'(-$signed({1'b0, root}));
			end
			res.cx = cl[0][CW-1:0];
			res.cy = cl[1][CW-1:0];
			res.cz = cl[2][CW-1:0];
			return res;
		endfunction

		function void note_input(coord_t p[3], coord_t s[3], coord_t e[3]);
			pending.push_back(predict(p, s, e));
		endfunction

		function void check_result(distance_result_t got);
			distance_result_t exp_r;
			if (pending.size() == 0) begin
				$error("unexpected result item: no prediction pending");
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			n_checked++;
			if (exp_r.reg_code <= REG_WITHIN)
				n_region[exp_r.reg_code]++;
			if (got.sdist !== exp_r.sdist) begin
				$error("signed_distance: expected %0d, got %0d", exp_r.sdist, got.sdist);
				errors++;
			end
			if (got.cx !== exp_r.cx) begin
				$error("closest_x: expected %0d, got %0d", exp_r.cx, got.cx);
				errors++;
			end
			if (got.cy !== exp_r.cy) begin
				$error("closest_y: expected %0d, got %0d", exp_r.cy, got.cy);
				errors++;
			end
			if (got.cz !== exp_r.cz) begin
				$error("closest_z: expected %0d, got %0d", exp_r.cz, got.cz);
				errors++;
			end
			if (got.reg_code !== exp_r.reg_code) begin
				$error("region: expected %0d, got %0d", exp_r.reg_code, got.reg_code);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	coord_t point_x, point_y, point_z;
	coord_t start_x, start_y, start_z;
	coord_t end_x, end_y, end_z;
	logic out_valid;
	logic out_ready;
	logic signed [DW-1:0] signed_distance;
	coord_t closest_x, closest_y, closest_z;
	region_t region;

	distance_scoreboard sb;
	bit stim_done;
	int n_sent;

	point_segment_distance #(.COORD_WIDTH(CW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.start_x(start_x),
		.start_y(start_y),
		.start_z(start_z),
		.end_x(end_x),
		.end_y(end_y),
		.end_z(end_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.signed_distance(signed_distance),
		.closest_x(closest_x),
		.closest_y(closest_y),
		.closest_z(closest_z),
		.region(region)
	);

	// Free-running clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Sends one item after a random gap and holds it until accepted.
	task automatic send_item(coord_t p[3], coord_t s[3], coord_t e[3]);
		int gap;
		gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		point_x <= p[0];
		point_y <= p[1];
		point_z <= p[2];
		start_x <= s[0];
		start_y <= s[1];
		start_z <= s[2];
		end_x <= e[0];
		end_y <= e[1];
		end_z <= e[2];
		do @(posedge clk); while (!in_ready);
		sb.note_input(p, s, e);
		n_sent++;
		@(negedge clk);
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 2047)) - 1024);
			2: return ($urandom_range(0, 1) != 0) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			default: return coord_t'($signed($urandom_range(0, 65535)) - 32768);
		endcase
	endfunction

	// Receiver with random stalls.
	initial begin
		distance_result_t got;
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.sdist = signed_distance;
			got.cx = closest_x;
			got.cy = closest_y;
			got.cz = closest_z;
			got.reg_code = region;
			sb.check_result(got);
		end
	end

	// Stimulus: directed corner cases, then random items.
	initial begin
		coord_t p[3], s[3], e[3];
		coord_t vmax, vmin;
		int mode;
		sb = new();
		stim_done = 0;
		n_sent = 0;
		vmax = {1'b0, {(CW-1){1'b1}}};
		vmin = {1'b1, {(CW-1){1'b0}}};
		arst_n = 1'b0;
		in_valid = 1'b0;
		{point_x, point_y, point_z} = '0;
		{start_x, start_y, start_z} = '0;
		{end_x, end_y, end_z} = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero-length segment at the origin and at the extremes.
		p = '{256, -512, 768}; s = '{0, 0, 0}; e = '{0, 0, 0};
		send_item(p, s, e);
		p = '{vmin, vmin, vmin}; s = '{vmax, vmax, vmax}; e = '{vmax, vmax, vmax};
		send_item(p, s, e);
		// Point exactly on the start and on the end (endpoints count as within).
		p = '{100, 200, 300}; s = '{100, 200, 300}; e = '{900, -50, 40};
		send_item(p, s, e);
		p = '{900, -50, 40}; s = '{100, 200, 300}; e = '{900, -50, 40};
		send_item(p, s, e);
		// Before the start, beyond the end, within.
		p = '{-1000, 5, 0}; s = '{0, 0, 0}; e = '{1000, 0, 0};
		send_item(p, s, e);
		p = '{3000, 7, -9}; s = '{0, 0, 0}; e = '{1000, 0, 0};
		send_item(p, s, e);
		p = '{500, 333, -77}; s = '{0, 0, 0}; e = '{1000, 0, 0};
		send_item(p, s, e);
		// Negative direction components exercise the floor rounding.
		p = '{1, 2, 3}; s = '{0, 0, 0}; e = '{-7, -3, -11};
		send_item(p, s, e);
		p = '{-5, -1, -6}; s = '{0, 0, 0}; e = '{-7, -3, -11};
		send_item(p, s, e);
		// Extreme coordinates, within the segment and before the start.
		p = '{vmax, vmax, vmax}; s = '{vmin, vmin, vmin}; e = '{vmax, vmax, vmax};
		send_item(p, s, e);
		p = '{vmin, vmin, vmin}; s = '{vmin, vmin, vmin}; e = '{vmax, vmax, vmax};
		send_item(p, s, e);
		p = '{vmax, vmin, vmax}; s = '{vmin, vmax, vmin}; e = '{vmax, vmin, vmax};
		send_item(p, s, e);
		p = '{vmin, vmax, vmin}; s = '{0, 0, 0}; e = '{vmax, vmin, vmax};
		send_item(p, s, e);
		p = '{vmax, vmax, vmax}; s = '{0, 0, 0}; e = '{vmin, vmin, vmin};
		send_item(p, s, e);
		p = '{-1, -1, -1}; s = '{vmin, 0, vmax}; e = '{vmax, -1, vmin};
		send_item(p, s, e);

		// Random items, some well scaled, others at full range or extremes.
		for (int n = 0; n < N_RANDOM; n++) begin
			mode = $urandom_range(0, 9);
			mode = (mode < 4) ? 0 : (mode < 6) ? 1 : (mode < 7) ? 2 : 3;
			for (int i = 0; i < 3; i++) begin
				p[i] = rand_coord(mode);
				s[i] = rand_coord(mode);
				e[i] = rand_coord(mode);
			end
			// Occasionally collapse the segment or put the point on it.
			case ($urandom_range(0, 15))
				0: e = s;
				1: p = s;
				2: p = e;
				default: ;
			endcase
			send_item(p, s, e);
		end
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// Completion: drain, wait out the pipeline, and report.
	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("Sent %0d items, checked %0d results.", n_sent, sb.n_checked);
		$display("Regions seen: %0d before, %0d beyond, %0d within.",
			sb.n_region[0], sb.n_region[1], sb.n_region[2]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Timeout waiting for the block.");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

>>> point_segment_distance.f
hdl/psd_pkg.sv
hdl/point_segment_distance.sv
sim/tb_point_segment_distance.sv
